@@ rtl/srs_pkg.sv @@
package srs_pkg;

  localparam int MAX_ENTRIES = 65536;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int LEN_W       = 17;
  localparam int IDX_W       = 16;
  localparam int DATA_W      = 32;
  localparam int LEN_LIMIT   = (MAX_ENTRIES < 65536) ? MAX_ENTRIES : 65536;

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_ADDR_W-3:0] REG_ARRAY_LENGTH = '0;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic                     req_type;
    logic [IDX_W-1:0]         entry_index;
    logic signed [DATA_W-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] last_index;
  } out_item_t;

  typedef enum logic [1:0] {
    ADDR_MID_CUR = 2'd0,
    ADDR_MID_NXT = 2'd1,
    ADDR_LO_CUR  = 2'd2,
    ADDR_LO_NXT  = 2'd3
  } addr_sel_t;

  typedef struct packed {
    logic      take;
    logic      upd;
    logic      upper;
    logic      save_first;
    logic      load_out;
    addr_sel_t addr_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic len_zero;
    logic cur_lt;
    logic nxt_lt;
    logic match;
    logic out_free;
  } dp_stat_t;

endpackage

@@ rtl/srs_ram.sv @@
module srs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/srs_ctrl.sv @@
module srs_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_is_query,
  output logic             in_ready,
  output srs_pkg::dp_cmd_t cmd,
  input  srs_pkg::dp_stat_t stat
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_LB_START = 7'b0000010,
    S_LB_PROBE = 7'b0000100,
    S_LB_CHECK = 7'b0001000,
    S_UB_START = 7'b0010000,
    S_UB_PROBE = 7'b0100000,
    S_FINISH   = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.addr_sel   = srs_pkg::ADDR_LO_CUR;
    in_ready       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (in_is_query) begin
            state_nxt = S_LB_START;
          end
        end
      end
      S_LB_START: begin
        if (stat.len_zero) begin
          state_nxt = S_FINISH;
        end else if (stat.cur_lt) begin
          cmd.addr_sel = srs_pkg::ADDR_MID_CUR;
          state_nxt    = S_LB_PROBE;
        end else begin
          cmd.addr_sel = srs_pkg::ADDR_LO_CUR;
          state_nxt    = S_LB_CHECK;
        end
      end
      S_LB_PROBE: begin
        cmd.upd = 1'b1;
        if (stat.nxt_lt) begin
          cmd.addr_sel = srs_pkg::ADDR_MID_NXT;
        end else begin
          cmd.addr_sel = srs_pkg::ADDR_LO_NXT;
          state_nxt    = S_LB_CHECK;
        end
      end
      S_LB_CHECK: begin
        if (stat.match) begin
          cmd.save_first = 1'b1;
          state_nxt      = S_UB_START;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_UB_START: begin
        cmd.upper = 1'b1;
        if (stat.cur_lt) begin
          cmd.addr_sel = srs_pkg::ADDR_MID_CUR;
          state_nxt    = S_UB_PROBE;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_UB_PROBE: begin
        cmd.upper = 1'b1;
        cmd.upd   = 1'b1;
        if (stat.nxt_lt) begin
          cmd.addr_sel = srs_pkg::ADDR_MID_NXT;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/srs_dp.sv @@
module srs_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  srs_pkg::dp_cmd_t                  cmd,
  output srs_pkg::dp_stat_t                 stat,
  input  srs_pkg::in_item_t                 in_data,
  input  logic [srs_pkg::LEN_W-1:0]         array_length,
  output logic                              out_valid,
  input  logic                              out_ready,
  output srs_pkg::out_item_t                out_data
);

  localparam int AW = srs_pkg::ADDR_W;

  function automatic logic [AW-1:0] mid_of(input logic [AW-1:0] lo, input logic [AW-1:0] hi,
                                           input logic up);
    logic [AW:0] s;
    s = {1'b0, lo} + {1'b0, hi} + (AW+1)'(up);
    return s[AW:1];
  endfunction

  logic [srs_pkg::LEN_W-1:0]         len_sat;
  logic signed [srs_pkg::DATA_W-1:0] key_r;
  logic                              len_zero_r;
  logic [AW-1:0]                     hi_init_r;
  logic [AW-1:0]                     lo_r;
  logic [AW-1:0]                     hi_r;
  logic [AW-1:0]                     mid_r;
  logic [AW-1:0]                     first_r;
  logic                              found_r;
  logic [AW-1:0]                     lo_nxt;
  logic [AW-1:0]                     hi_nxt;
  logic [AW-1:0]                     rd_addr;
  logic [srs_pkg::DATA_W-1:0]        rd_data;
  logic signed [srs_pkg::DATA_W-1:0] rd_val;
  logic                              wr_en;
  logic                              out_valid_r;
  srs_pkg::out_item_t                out_r;

  assign len_sat = (array_length > srs_pkg::LEN_W'(srs_pkg::LEN_LIMIT)) ?
                   srs_pkg::LEN_W'(srs_pkg::LEN_LIMIT) : array_length;

  assign wr_en = cmd.take && (in_data.req_type == srs_pkg::REQ_WRITE) &&
                 (32'(in_data.entry_index) < srs_pkg::MAX_ENTRIES);

  srs_ram #(
    .WIDTH (srs_pkg::DATA_W),
    .DEPTH (srs_pkg::MAX_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_data.entry_index)),
    .wr_data (in_data.item_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_val = $signed(rd_data);

  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (!cmd.upper) begin
      if (rd_val >= key_r) begin
        hi_nxt = mid_r;
      end else begin
        lo_nxt = mid_r + 1'b1;
      end
    end else begin
      if (rd_val <= key_r) begin
        lo_nxt = mid_r;
      end else begin
        hi_nxt = mid_r - 1'b1;
      end
    end
  end

  always_comb begin
    unique case (cmd.addr_sel)
      srs_pkg::ADDR_MID_CUR: rd_addr = mid_of(lo_r, hi_r, cmd.upper);
      srs_pkg::ADDR_MID_NXT: rd_addr = mid_of(lo_nxt, hi_nxt, cmd.upper);
      srs_pkg::ADDR_LO_CUR:  rd_addr = lo_r;
      srs_pkg::ADDR_LO_NXT:  rd_addr = lo_nxt;
      default:               rd_addr = lo_r;
    endcase
  end

  always_ff @(posedge clk) begin
    mid_r <= rd_addr;
    if (cmd.take) begin
      key_r      <= in_data.item_value;
      len_zero_r <= (len_sat == '0);
      hi_init_r  <= AW'(len_sat - 1'b1);
      lo_r       <= '0;
      hi_r       <= AW'(len_sat - 1'b1);
      found_r    <= 1'b0;
    end else if (cmd.save_first) begin
      first_r <= lo_r;
      found_r <= 1'b1;
      lo_r    <= '0;
      hi_r    <= hi_init_r;
    end else if (cmd.upd) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
    if (cmd.load_out) begin
      if (found_r) begin
        out_r.found       <= 1'b1;
        out_r.first_index <= srs_pkg::IDX_W'(first_r);
        out_r.last_index  <= srs_pkg::IDX_W'(lo_r);
      end else begin
        out_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.len_zero = len_zero_r;
  assign stat.cur_lt   = (lo_r < hi_r);
  assign stat.nxt_lt   = (lo_nxt < hi_nxt);
  assign stat.match    = (rd_val == key_r);
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/sorted_range_search_core.sv @@
// channel  | handshake         | payload
// in       | in_valid/ready    | in_data   (req_type, entry_index, item_value)
// out      | out_valid/ready   | out_data  (found, first_index, last_index)
// cfg      | apb psel/penable  | cfg_pwdata -> array_length at byte 0
//
// a write item is taken in the idle state; a query runs a lower-bound search, then an
// upper-bound search on a hit (skipped on a miss), one table read per probe cycle
// the table ram has a single read port, which sets the probe rate
// sync active-low reset clears control state and array_length; the table is not cleared
// a held result stalls the next query in its last cycle until out_ready

module sorted_range_search_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  srs_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output srs_pkg::out_item_t                 out_data,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [srs_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [srs_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [srs_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);

  logic [srs_pkg::LEN_W-1:0] array_length_r;
  logic                      cfg_hit;
  srs_pkg::dp_cmd_t          cmd;
  srs_pkg::dp_stat_t         stat;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[srs_pkg::CFG_ADDR_W-1:2] == srs_pkg::REG_ARRAY_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      array_length_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
      array_length_r <= cfg_pwdata[srs_pkg::LEN_W-1:0];
    end
  end

  assign cfg_prdata = cfg_hit ? srs_pkg::CFG_DATA_W'(array_length_r) : '0;

  srs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_is_query (in_data.req_type == srs_pkg::REQ_QUERY),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .stat        (stat)
  );

  srs_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_data      (in_data),
    .array_length (array_length_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

`ifndef SYNTHESIS
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.req_type == srs_pkg::REQ_WRITE)) |=> !$rose(out_valid))
    else $error("write transfer produced a result");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.req_type == srs_pkg::REQ_QUERY)) |=> !in_ready)
    else $error("input taken while a query is running");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |-> (out_data.first_index == '0 && out_data.last_index == '0))
    else $error("miss result carries nonzero indices");
`endif

endmodule

@@ sim/tb_sorted_range_search_core.sv @@
module tb_sorted_range_search_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [srs_pkg::DATA_W-1:0] val_t;
  typedef logic [srs_pkg::CFG_ADDR_W-1:0] cfg_addr_t;
  typedef logic [srs_pkg::CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_addr_t REG_LEN_ADDR   = {srs_pkg::REG_ARRAY_LENGTH, 2'b00};
  localparam cfg_addr_t REG_SPARE_ADDR = cfg_addr_t'(4);
  localparam val_t VAL_MIN = {1'b1, {(srs_pkg::DATA_W-1){1'b0}}};
  localparam val_t VAL_MAX = {1'b0, {(srs_pkg::DATA_W-1){1'b1}}};
  localparam int SETTLE_CYCLES = 50;
  localparam int unsigned ITEM_TARGET = 1400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  srs_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  srs_pkg::out_item_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  cfg_addr_t cfg_paddr = '0;
  cfg_data_t cfg_pwdata = '0;
  cfg_data_t cfg_prdata;
  logic cfg_pready;

  val_t shadow_vals [srs_pkg::MAX_ENTRIES];
  bit touched [int unsigned];
  logic [srs_pkg::LEN_W-1:0] cfg_len = '0;
  srs_pkg::out_item_t pending_lookups [$];
  int err_count = 0;
  int unsigned items_sent = 0;
  bit quiet = 1'b0;
  int hold_cycles = 0;
  bit ready_state = 1'b1;
  int ready_run = 0;

  sorted_range_search_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #6 clk = ~clk;

  task automatic note_error(input string msg);
    err_count++;
    $display("%0t mismatch: %s", $realtime, msg);
  endtask

  // lower bound, then upper bound on a hit, over the searched prefix
  function automatic srs_pkg::out_item_t range_lookup(input val_t key);
    srs_pkg::out_item_t r;
    int unsigned n, lo, hi, mid, first;
    r = '0;
    n = (cfg_len > srs_pkg::LEN_LIMIT) ? srs_pkg::LEN_LIMIT : cfg_len;
    if (n == 0) return r;
    lo = 0;
    hi = n - 1;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (shadow_vals[mid] >= key) hi = mid;
      else lo = mid + 1;
    end
    if (shadow_vals[lo] != key) return r;
    first = lo;
    lo = 0;
    hi = n - 1;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (shadow_vals[mid] <= key) lo = mid;
      else hi = mid - 1;
    end
    r.found = 1'b1;
    r.first_index = first[srs_pkg::IDX_W-1:0];
    r.last_index = lo[srs_pkg::IDX_W-1:0];
    return r;
  endfunction

  // sorted contents of the large table, defined for every index
  function automatic val_t full_val(input int unsigned i);
    if (i == srs_pkg::MAX_ENTRIES - 1) return VAL_MAX;
    return val_t'(32'h8000_0000 + (i >> 1) * 32'd131072);
  endfunction

  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(input srs_pkg::in_item_t item);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (item.req_type == srs_pkg::REQ_QUERY) begin
      pending_lookups.push_back(range_lookup(item.item_value));
    end else if (item.entry_index < srs_pkg::MAX_ENTRIES) begin
      shadow_vals[item.entry_index] = item.item_value;
    end
  endtask

  task automatic write_entry(input int unsigned idx, input val_t v);
    srs_pkg::in_item_t item;
    item.req_type = srs_pkg::REQ_WRITE;
    item.entry_index = idx[srs_pkg::IDX_W-1:0];
    item.item_value = v;
    send_item(item);
  endtask

  task automatic query_key(input val_t key);
    srs_pkg::in_item_t item;
    item.req_type = srs_pkg::REQ_QUERY;
    item.entry_index = srs_pkg::IDX_W'($urandom());
    item.item_value = key;
    send_item(item);
  endtask

  task automatic touch(input int unsigned i);
    if (!touched.exists(i)) begin
      touched[i] = 1'b1;
      write_entry(i, full_val(i));
    end
  endtask

  // write every large-table entry that both searches for this key will probe
  task automatic prime_key(input val_t key);
    int unsigned n, lo, hi, mid;
    n = (cfg_len > srs_pkg::LEN_LIMIT) ? srs_pkg::LEN_LIMIT : cfg_len;
    if (n == 0) return;
    lo = 0;
    hi = n - 1;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      touch(mid);
      if (full_val(mid) >= key) hi = mid;
      else lo = mid + 1;
    end
    touch(lo);
    if (full_val(lo) != key) return;
    lo = 0;
    hi = n - 1;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      touch(mid);
      if (full_val(mid) <= key) lo = mid;
      else hi = mid - 1;
    end
  endtask

  task automatic full_query(input val_t key);
    prime_key(key);
    query_key(key);
  endtask

  // drop valid, wait for every lookup to come back, then let the core go idle
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input cfg_addr_t addr,
                          input cfg_data_t wdata,
                          output cfg_data_t rdata);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= addr;
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_length(input int unsigned len);
    cfg_data_t rd;
    settle();
    apb_xfer(1'b1, REG_LEN_ADDR, len, rd);
    cfg_len = len[srs_pkg::LEN_W-1:0];
    apb_xfer(1'b0, REG_LEN_ADDR, '0, rd);
    if (rd[srs_pkg::LEN_W-1:0] !== cfg_len) begin
      note_error($sformatf("array_length readback %0d, wrote %0d",
                           rd[srs_pkg::LEN_W-1:0], cfg_len));
    end
  endtask

  task automatic poke_spare(input cfg_data_t v);
    cfg_data_t rd;
    settle();
    apb_xfer(1'b1, REG_SPARE_ADDR, v, rd);
  endtask

  task automatic check_result(input srs_pkg::out_item_t got);
    srs_pkg::out_item_t want;
    if (pending_lookups.size() == 0) begin
      note_error($sformatf("result with no lookup pending: found=%0d first=%0d last=%0d",
                           got.found, got.first_index, got.last_index));
      return;
    end
    want = pending_lookups.pop_front();
    if (got.found !== want.found) begin
      note_error($sformatf("found %0d, expected %0d", got.found, want.found));
    end
    if (got.first_index !== want.first_index) begin
      note_error($sformatf("first_index %0d, expected %0d", got.first_index, want.first_index));
    end
    if (got.last_index !== want.last_index) begin
      note_error($sformatf("last_index %0d, expected %0d", got.last_index, want.last_index));
    end
  endtask

  // result side: check each transfer, then pick the next ready level
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      check_result(out_data);
    end
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_ready <= 1'b0;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else begin
      if (ready_run == 0) begin
        ready_state = ($urandom_range(0, 2) != 0);
        if (ready_state) ready_run = $urandom_range(1, 8);
        else if ($urandom_range(0, 99) < 85) ready_run = $urandom_range(1, 3);
        else ready_run = $urandom_range(10, 60);
      end
      ready_run = ready_run - 1;
      out_ready <= ready_state;
    end
  end

  task automatic test_empty_table();
    set_length(0);
    query_key(VAL_MIN);
    query_key(VAL_MAX);
    query_key(0);
  endtask

  task automatic test_small_table();
    val_t demo [8];
    demo = '{VAL_MIN, -5, -5, 0, 7, 7, 7, VAL_MAX};
    for (int i = 0; i < 8; i++) write_entry(i, demo[i]);
    set_length(8);
    poke_spare($urandom());
    query_key(VAL_MIN);
    query_key(VAL_MAX);
    query_key(-5);
    query_key(7);
    query_key(0);
    query_key(1);
    query_key(-6);
    query_key(VAL_MAX - 1);
    set_length(1);
    query_key(VAL_MIN);
    query_key(-5);
    // unsorted table
    write_entry(2, 100);
    set_length(8);
    query_key(100);
    query_key(7);
    query_key(-5);
  endtask

  task automatic test_full_table();
    int unsigned idx;
    touched.delete();
    set_length(srs_pkg::MAX_ENTRIES);
    full_query(VAL_MIN);
    full_query(VAL_MAX);
    full_query(full_val(srs_pkg::MAX_ENTRIES - 2));
    repeat (6) full_query(full_val($urandom_range(0, srs_pkg::MAX_ENTRIES - 1)));
    repeat (4) begin
      idx = $urandom_range(0, srs_pkg::MAX_ENTRIES - 3);
      full_query(full_val(idx) + 1);
    end
    set_length(srs_pkg::MAX_ENTRIES - 1);
    full_query(VAL_MAX);
    full_query(full_val(srs_pkg::MAX_ENTRIES - 2));
    set_length(srs_pkg::MAX_ENTRIES / 2);
    full_query(full_val(srs_pkg::MAX_ENTRIES / 2 - 1));
    full_query(full_val(srs_pkg::MAX_ENTRIES / 2));
  endtask

  task automatic test_back_pressure();
    val_t keys [12];
    settle();
    quiet = 1'b1;
    foreach (keys[k]) begin
      keys[k] = full_val($urandom_range(0, srs_pkg::MAX_ENTRIES / 2 - 1));
      prime_key(keys[k]);
    end
    hold_cycles = 600;
    foreach (keys[k]) query_key(keys[k]);
    quiet = 1'b0;
  endtask

  task automatic test_random_tables();
    int unsigned len, n, idx, r;
    longint v;
    val_t key;
    while (items_sent < ITEM_TARGET) begin
      quiet = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 5) len = 0;
      else if (r < 75) len = $urandom_range(1, 16);
      else if (r < 95) len = $urandom_range(17, 64);
      else len = $urandom_range(65, 300);
      if ($urandom_range(0, 6) == 0) v = VAL_MIN;
      else v = longint'($signed($urandom()));
      // sorted prefix with runs of equal keys
      for (int unsigned i = 0; i < len; i++) begin
        write_entry(i, v[srs_pkg::DATA_W-1:0]);
        r = $urandom_range(0, 9);
        if (r >= 8) v = v + $urandom_range(1, 1 << 24);
        else if (r >= 3) v = v + $urandom_range(1, 5);
        if (v > VAL_MAX) v = VAL_MAX;
      end
      set_length(len);
      n = $urandom_range(4, 16);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          if (len > 0 && $urandom_range(0, 1)) idx = $urandom_range(0, len - 1);
          else idx = $urandom_range(0, srs_pkg::MAX_ENTRIES - 1);
          write_entry(idx, $urandom());
        end else begin
          idx = (len > 0) ? $urandom_range(0, len - 1) : 0;
          key = shadow_vals[idx];
          if (len == 0 || r >= 80) begin
            if (r < 92) key = $urandom();
            else key = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
          end else if (r >= 70) begin
            key = key - 1;
          end else if (r >= 55) begin
            key = key + 1;
          end
          query_key(key);
        end
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_small_table();
    test_full_table();
    test_back_pressure();
    test_random_tables();
    settle();
    if (err_count == 0) begin
      $display("tb_sorted_range_search_core OK");
    end else begin
      $display("tb_sorted_range_search_core NOT OK");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("tb_sorted_range_search_core NOT OK");
    $finish;
  end

endmodule

@@ sorted_range_search_core.f @@
rtl/srs_pkg.sv
rtl/srs_ram.sv
rtl/srs_ctrl.sv
rtl/srs_dp.sv
rtl/sorted_range_search_core.sv
sim/tb_sorted_range_search_core.sv
